FILE: hw/rtl/abrss_pkg.sv
// ----------------------------------------------------------------------------
// abrss_pkg
// Shared types and constants for the ATA byte-range sector splitter.
// ----------------------------------------------------------------------------
package abrss_pkg;

  // fixed field widths of the request and result beats
  localparam int unsigned ADDR_W  = 37;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned LBA_W   = 28;
  localparam int unsigned DEV_W   = 8;
  localparam int unsigned SOFF_W  = 9;
  localparam int unsigned CNT_W   = 10;
  localparam int unsigned DOFF_W  = 15;

  // width of the span calculation: sector offset plus length
  localparam int unsigned SPAN_W  = 17;

  // base value of the ATA device register: LBA mode, obsolete bits set
  localparam logic [DEV_W-1:0] DEV_SEL_BASE = 8'hE0;

  // request action codes
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_ERROR
  } abrss_state_t;

endpackage

FILE: hw/rtl/ata_byte_range_sector_splitter_unit.sv
// ----------------------------------------------------------------------------
// ata_byte_range_sector_splitter_unit
// Splits one byte-range disk request into per-sector ATA operations.
// ----------------------------------------------------------------------------
// The request is loaded into the working registers; the sequencer then
// registers one result beat per cycle while the output is not stalled. A span
// error gives a single error beat and a zero-length request none. No new
// request is taken until the last piece is cut by the single subtract/compare
// unit, which cuts one sector piece per cycle while the output is not stalled.
// Reset: synchronous, active low; clears the sequencer and the output valid.
module ata_byte_range_sector_splitter_unit
  import abrss_pkg::*;
#(
  parameter int unsigned SECTOR_BYTES     = 512,
  parameter int unsigned MAX_SPAN_SECTORS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_action,
  input  logic                in_drive,
  input  logic [ADDR_W-1:0]   in_byte_address,
  input  logic [LEN_W-1:0]    in_byte_length,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [LBA_W-1:0]    out_sector_lba,
  output logic [DEV_W-1:0]    out_device_select,
  output logic [SOFF_W-1:0]   out_sector_offset,
  output logic [CNT_W-1:0]    out_byte_count,
  output logic [DOFF_W-1:0]   out_data_offset,
  output logic                out_read_first,
  output logic                out_write_back,
  output logic                out_last,
  output logic                out_span_error
);

  localparam int unsigned SB_W = $clog2(SECTOR_BYTES);
  localparam int unsigned RM_W = SB_W + 1;
  localparam int unsigned DF_W = LEN_W + 1;

  // sequencer and working registers
  abrss_state_t        state_r, state_nxt;
  logic                is_write_r;
  logic                drive_r;
  logic [LBA_W-1:0]    lba_r;
  logic [SB_W-1:0]     off_r;
  logic [LEN_W-1:0]    rem_r;
  logic [DOFF_W-1:0]   doff_r;

  // output register
  logic                out_valid_r;
  logic [LBA_W-1:0]    out_lba_r;
  logic [DEV_W-1:0]    out_dev_r;
  logic [SOFF_W-1:0]   out_soff_r;
  logic [CNT_W-1:0]    out_cnt_r;
  logic [DOFF_W-1:0]   out_doff_r;
  logic                out_rf_r;
  logic                out_wb_r;
  logic                out_last_r;
  logic                out_err_r;

  logic                in_fire;
  logic                out_free;
  logic                step;
  logic [ADDR_W-1:0]   addr_sec;
  logic [SPAN_W-1:0]   span_end;
  logic [SPAN_W-1:0]   span_m1;
  logic                span_bad;
  logic [RM_W-1:0]     room;
  logic [DF_W-1:0]     diff;
  logic                fin;
  logic [RM_W-1:0]     cnt;
  logic                partial;

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  // request decode: first sector and span check
  assign addr_sec = in_byte_address >> SB_W;
  assign span_end = SPAN_W'(in_byte_address[SB_W-1:0]) + SPAN_W'(in_byte_length)
                    - SPAN_W'(1);
  assign span_m1  = span_end >> SB_W;
  assign span_bad = (span_m1 >= SPAN_W'(MAX_SPAN_SECTORS));

  // shared cut unit: remaining length against room left in the sector
  assign room    = RM_W'(SECTOR_BYTES) - RM_W'(off_r);
  assign diff    = DF_W'(rem_r) - DF_W'(room);
  assign fin     = diff[DF_W-1] || (diff == '0);
  assign cnt     = diff[DF_W-1] ? rem_r[RM_W-1:0] : room;
  assign partial = (cnt != RM_W'(SECTOR_BYTES));

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    step      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_byte_length != '0)) begin
          state_nxt = span_bad ? ST_ERROR : ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (out_free) begin
          step = 1'b1;
          if (fin) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ERROR: begin
        if (out_free) begin
          step      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working registers: load on request, advance one sector per step
  always_ff @(posedge clk) begin
    if (in_fire) begin
      is_write_r <= (in_action == ACT_WRITE);
      drive_r    <= in_drive;
      lba_r      <= addr_sec[LBA_W-1:0];
      off_r      <= in_byte_address[SB_W-1:0];
      rem_r      <= in_byte_length;
      doff_r     <= '0;
    end else if (step && (state_r == ST_SPLIT)) begin
      lba_r  <= lba_r + LBA_W'(1);
      off_r  <= '0;
      rem_r  <= fin ? '0 : diff[LEN_W-1:0];
      doff_r <= doff_r + DOFF_W'(cnt);
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (step) begin
      if (state_r == ST_ERROR) begin
        out_lba_r  <= '0;
        out_dev_r  <= '0;
        out_soff_r <= '0;
        out_cnt_r  <= '0;
        out_doff_r <= '0;
        out_rf_r   <= 1'b0;
        out_wb_r   <= 1'b0;
        out_last_r <= 1'b1;
        out_err_r  <= 1'b1;
      end else begin
        out_lba_r  <= lba_r;
        out_dev_r  <= DEV_SEL_BASE | {3'b000, drive_r, lba_r[LBA_W-1 -: 4]};
        out_soff_r <= off_r[SOFF_W-1:0];
        out_cnt_r  <= cnt[CNT_W-1:0];
        out_doff_r <= doff_r;
        out_rf_r   <= is_write_r ? partial : 1'b1;
        out_wb_r   <= is_write_r;
        out_last_r <= fin;
        out_err_r  <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sector_lba    = out_lba_r;
  assign out_device_select = out_dev_r;
  assign out_sector_offset = out_soff_r;
  assign out_byte_count    = out_cnt_r;
  assign out_data_offset   = out_doff_r;
  assign out_read_first    = out_rf_r;
  assign out_write_back    = out_wb_r;
  assign out_last          = out_last_r;
  assign out_span_error    = out_err_r;

endmodule

FILE: hw/rtl/abrss_checker.sv
// ----------------------------------------------------------------------------
// abrss_checker
// Port-level checks for the ATA byte-range sector splitter.
// ----------------------------------------------------------------------------
module abrss_checker
  import abrss_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                in_action,
  input logic                in_drive,
  input logic [ADDR_W-1:0]   in_byte_address,
  input logic [LEN_W-1:0]    in_byte_length,
  input logic                out_valid,
  input logic                out_stall,
  input logic [LBA_W-1:0]    out_sector_lba,
  input logic [DEV_W-1:0]    out_device_select,
  input logic [SOFF_W-1:0]   out_sector_offset,
  input logic [CNT_W-1:0]    out_byte_count,
  input logic [DOFF_W-1:0]   out_data_offset,
  input logic                out_read_first,
  input logic                out_write_back,
  input logic                out_last,
  input logic                out_span_error
);

  // the splitter is busy in the cycle after it takes a non-empty request
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_byte_length != '0)) |=> in_stall)
    else $error("splitter free right after a non-empty request");

  // an error beat is always the final beat of its request
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_span_error) |-> out_last)
    else $error("span error beat without last");

  // an error beat carries no sector operation
  a_err_no_op: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_span_error) |->
      ((out_byte_count == '0) && !out_read_first && !out_write_back))
    else $error("span error beat carries an operation");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_sector_lba)
      && $stable(out_last)))
    else $error("stalled result beat changed");

endmodule

bind ata_byte_range_sector_splitter_unit abrss_checker u_abrss_checker (.*);

FILE: test/abrss_split_checker.sv
// ----------------------------------------------------------------------------
// abrss_split_checker
// Watches the request and result channels of the sector splitter. Each
// request taken is cut into its expected sector operations, which are queued
// in order and compared field by field with the result beats as they leave.
// ----------------------------------------------------------------------------
module abrss_split_checker
  import abrss_pkg::*;
#(
  parameter int unsigned SECTOR_BYTES     = 512,
  parameter int unsigned MAX_SPAN_SECTORS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_action,
  input  logic              in_drive,
  input  logic [ADDR_W-1:0] in_byte_address,
  input  logic [LEN_W-1:0]  in_byte_length,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [LBA_W-1:0]  out_sector_lba,
  input  logic [DEV_W-1:0]  out_device_select,
  input  logic [SOFF_W-1:0] out_sector_offset,
  input  logic [CNT_W-1:0]  out_byte_count,
  input  logic [DOFF_W-1:0] out_data_offset,
  input  logic              out_read_first,
  input  logic              out_write_back,
  input  logic              out_last,
  input  logic              out_span_error,
  output int unsigned       ops_pending,
  output int unsigned       mismatch_count
);

  // one sector operation, fields in port order
  typedef struct packed {
    logic [LBA_W-1:0]  sector_lba;
    logic [DEV_W-1:0]  device_select;
    logic [SOFF_W-1:0] sec_off;
    logic [CNT_W-1:0]  byte_count;
    logic [DOFF_W-1:0] data_offset;
    logic              read_first;
    logic              write_back;
    logic              last;
    logic              span_error;
  } sector_op_t;

  sector_op_t  expected_ops[$];
  int unsigned beats_seen;

  initial begin
    ops_pending    = 0;
    mismatch_count = 0;
    beats_seen     = 0;
  end

  // one line per mismatch
  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch at result beat %0d: %s got 0x%0h, expected 0x%0h",
             beats_seen, what, got, want);
    mismatch_count++;
  endtask

  // cut one request into its sector operations and queue them
  function automatic void split_request(input logic action,
                                        input logic drive,
                                        input logic [ADDR_W-1:0] start_addr,
                                        input logic [LEN_W-1:0] length);
    logic [63:0] addr;
    logic [63:0] left;
    logic [63:0] first_sec;
    logic [63:0] last_sec;
    logic [63:0] sec;
    logic [63:0] off;
    logic [63:0] room;
    logic [63:0] cnt;
    logic [63:0] doff;
    sector_op_t  op;
    if (length == '0) return;
    addr      = 64'(start_addr);
    left      = 64'(length);
    first_sec = addr / SECTOR_BYTES;
    last_sec  = (addr + left - 64'd1) / SECTOR_BYTES;
    // too many sectors: a single error beat with everything else zero
    if (last_sec - first_sec + 64'd1 > 64'(MAX_SPAN_SECTORS)) begin
      op            = '0;
      op.last       = 1'b1;
      op.span_error = 1'b1;
      expected_ops.push_back(op);
      return;
    end
    doff = '0;
    while (left != '0) begin
      sec  = addr / SECTOR_BYTES;
      off  = addr % SECTOR_BYTES;
      room = 64'(SECTOR_BYTES) - off;
      cnt  = (left < room) ? left : room;
      op               = '0;
      op.sector_lba    = sec[LBA_W-1:0];
      op.device_select = DEV_SEL_BASE | {3'b000, drive, 4'h0} |
                         {4'h0, op.sector_lba[LBA_W-1 -: 4]};
      op.sec_off       = off[SOFF_W-1:0];
      op.byte_count    = cnt[CNT_W-1:0];
      op.data_offset   = doff[DOFF_W-1:0];
      // a write only needs the old sector when it covers part of it
      op.read_first    = (action == ACT_WRITE) ? (cnt < 64'(SECTOR_BYTES)) : 1'b1;
      op.write_back    = (action == ACT_WRITE);
      left             = left - cnt;
      op.last          = (left == '0);
      expected_ops.push_back(op);
      addr = addr + cnt;
      doff = doff + cnt;
    end
  endfunction

  // predict on request beats, compare on result beats
  always @(posedge clk) begin
    sector_op_t got;
    sector_op_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        split_request(in_action, in_drive, in_byte_address, in_byte_length);
      end
      if (out_valid && !out_stall) begin
        got = {out_sector_lba, out_device_select, out_sector_offset, out_byte_count,
               out_data_offset, out_read_first, out_write_back, out_last,
               out_span_error};
        if (expected_ops.size() == 0) begin
          flag_mismatch("result beat with nothing expected, sector_lba",
                        64'(got.sector_lba), '0);
        end else begin
          want = expected_ops.pop_front();
          if (got.sector_lba !== want.sector_lba)
            flag_mismatch("sector_lba", 64'(got.sector_lba), 64'(want.sector_lba));
          if (got.device_select !== want.device_select)
            flag_mismatch("device_select", 64'(got.device_select),
                          64'(want.device_select));
          if (got.sec_off !== want.sec_off)
            flag_mismatch("offset in sector", 64'(got.sec_off),
                          64'(want.sec_off));
          if (got.byte_count !== want.byte_count)
            flag_mismatch("byte_count", 64'(got.byte_count), 64'(want.byte_count));
          if (got.data_offset !== want.data_offset)
            flag_mismatch("data_offset", 64'(got.data_offset), 64'(want.data_offset));
          if (got.read_first !== want.read_first)
            flag_mismatch("read_first", 64'(got.read_first), 64'(want.read_first));
          if (got.write_back !== want.write_back)
            flag_mismatch("write_back", 64'(got.write_back), 64'(want.write_back));
          if (got.last !== want.last)
            flag_mismatch("last", 64'(got.last), 64'(want.last));
          if (got.span_error !== want.span_error)
            flag_mismatch("span_error", 64'(got.span_error), 64'(want.span_error));
        end
        beats_seen++;
      end
      ops_pending <= expected_ops.size();
    end
  end

endmodule

FILE: test/tb_ata_byte_range_sector_splitter_unit.sv
// ----------------------------------------------------------------------------
// tb_ata_byte_range_sector_splitter_unit
// Drives disk requests into the sector splitter: a directed set covering the
// corner cases, then random requests under three idling phases and one long
// output hold-off. The checker alongside predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_ata_byte_range_sector_splitter_unit
  import abrss_pkg::*;
();

  localparam int unsigned SEC_BYTES  = 512;
  localparam int unsigned SPAN_LIMIT = 64;
  localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_action;
  logic              in_drive;
  logic [ADDR_W-1:0] in_byte_address;
  logic [LEN_W-1:0]  in_byte_length;
  logic              out_valid;
  logic              out_stall;
  logic [LBA_W-1:0]  out_sector_lba;
  logic [DEV_W-1:0]  out_device_select;
  logic [SOFF_W-1:0] out_sector_offset;
  logic [CNT_W-1:0]  out_byte_count;
  logic [DOFF_W-1:0] out_data_offset;
  logic              out_read_first;
  logic              out_write_back;
  logic              out_last;
  logic              out_span_error;
  int unsigned       ops_pending;
  int unsigned       mismatch_count;

  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  logic              hold_token;

  ata_byte_range_sector_splitter_unit #(
    .SECTOR_BYTES    (SEC_BYTES),
    .MAX_SPAN_SECTORS(SPAN_LIMIT)
  ) dut (
    .*
  );

  abrss_split_checker #(
    .SECTOR_BYTES    (SEC_BYTES),
    .MAX_SPAN_SECTORS(SPAN_LIMIT)
  ) split_chk (
    .*
  );

  // clock, period 20
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result side: random stalls, or a long hold-off when asked for
  initial begin
    logic        hold_seen;
    int unsigned hold_left;
    out_stall = 1'b0;
    hold_seen = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // offer one request beat, with random idle cycles ahead of it
  task automatic issue_request(input logic action, input logic drive,
                               input logic [ADDR_W-1:0] addr,
                               input logic [LEN_W-1:0] length);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= action;
    in_drive        <= drive;
    in_byte_address <= addr;
    in_byte_length  <= length;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // mostly spans of a few sectors, some long ones, some zero or too long
  task automatic random_request();
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  length;
    int unsigned       pick;
    addr = ADDR_W'({$urandom(), $urandom()});
    pick = $urandom_range(99);
    if (pick < 30) begin
      addr[8:0] = '0;
    end else if (pick < 40) begin
      addr = ADDR_TOP - ADDR_W'($urandom_range(8191));
    end
    pick = $urandom_range(99);
    if (pick < 5) begin
      length = '0;
    end else if (pick < 13) begin
      length = LEN_W'($urandom_range(65535, 32000));
    end else if (pick < 50) begin
      length = LEN_W'($urandom_range(16, 1));
    end else if (pick < 85) begin
      length = LEN_W'($urandom_range(2048, 17));
    end else begin
      length = LEN_W'($urandom_range(32768, 2049));
    end
    issue_request(1'($urandom_range(1)), 1'($urandom_range(1)), addr, length);
  endtask

  // stimulus and verdict
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_action       = ACT_READ;
    in_drive        = 1'b0;
    in_byte_address = '0;
    in_byte_length  = '0;
    hold_token      = 1'b0;
    send_idle_pct   = 14;
    recv_idle_pct   = 61;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corner cases
    issue_request(ACT_READ,  1'b0, 37'd0, 16'd512);           // one whole sector
    issue_request(ACT_WRITE, 1'b1, 37'd0, 16'd512);           // whole sector write
    issue_request(ACT_WRITE, 1'b0, 37'd100, 16'd50);          // partial write
    issue_request(ACT_READ,  1'b1, 37'd500, 16'd100);         // crosses a boundary
    issue_request(ACT_READ,  1'b0, 37'd123, 16'd0);           // zero length read
    issue_request(ACT_WRITE, 1'b1, 37'd7, 16'd0);             // zero length, unaligned
    issue_request(ACT_WRITE, 1'b0, 37'd0, 16'd0);
    issue_request(ACT_READ,  1'b0, 37'd5120, 16'd32768);      // span limit, aligned
    issue_request(ACT_WRITE, 1'b1, 37'd1, 16'd32767);         // span limit, unaligned
    issue_request(ACT_READ,  1'b0, 37'd1, 16'd32768);         // one sector too many
    issue_request(ACT_WRITE, 1'b1, 37'd512, 16'd32769);       // length past 32768
    issue_request(ACT_WRITE, 1'b0, ADDR_TOP, 16'hFFFF);       // largest length
    issue_request(ACT_READ,  1'b1, ADDR_TOP, 16'd1);          // last byte of reach
    issue_request(ACT_WRITE, 1'b0, ADDR_TOP - 37'd511, 16'd1024); // lba wraps to 0
    issue_request(ACT_READ,  1'b1, 37'h15_5555_5400, 16'd1536); // high lba nibble
    issue_request(ACT_WRITE, 1'b1, 37'd511, 16'd1);           // last byte of a sector
    issue_request(ACT_WRITE, 1'b0, 37'd300, 16'd1500);        // partial head and tail
    issue_request(ACT_WRITE, 1'b1, 37'd1024, 16'd2048);       // whole sectors only
    issue_request(ACT_READ,  1'b0, 37'h0A_AAAA_AA00, 16'd512);

    // sender idles little, receiver often
    repeat (160) random_request();

    // the other way round
    send_idle_pct = 61;
    recv_idle_pct <= 14;
    repeat (160) random_request();

    // no idling; a long output hold-off first so the input backs up
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_token    <= ~hold_token;
    repeat (16) begin
      issue_request(1'($urandom_range(1)), 1'($urandom_range(1)),
                    ADDR_W'({$urandom(), $urandom()}), 16'd4096);
    end
    repeat (150) random_request();

    // drain, then wait out any stray beats
    in_valid <= 1'b0;
    @(posedge clk);
    wait (ops_pending == 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/abrss_pkg.sv
hw/rtl/ata_byte_range_sector_splitter_unit.sv
hw/rtl/abrss_checker.sv
test/abrss_split_checker.sv
test/tb_ata_byte_range_sector_splitter_unit.sv
